>>> rtl/core/sqsm_pkg.sv
// Shared types and constants of the shift queue with sum and mean.
package sqsm_pkg;

  // Default queue depth
  localparam int DEPTH_DEF = 8;

  // Fixed field widths
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 4;
  localparam int TOTAL_W  = 35;
  localparam int STATUS_W = 2;

  // Quotient bits resolved by the divider in one cycle
  localparam int DIV_STEP_BITS = 4;

  typedef enum logic [1:0] {
    ACT_ENQ = 2'd0,
    ACT_DEQ = 2'd1,
    ACT_CLR = 2'd2,
    ACT_QRY = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // Per-cell control: load the new word, or take the neighbor's word
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

endpackage

>>> rtl/core/sqsm_if.sv
// Valid/ready channel interfaces for queue commands and queue results.
interface sqsm_item_if;
  logic                                 valid;
  logic                                 ready;
  sqsm_pkg::action_t                    action;
  logic signed [sqsm_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output action, output value, input ready);
  modport sink   (input valid, input action, input value, output ready);
endinterface

interface sqsm_result_if;
  logic                                 valid;
  logic                                 ready;
  sqsm_pkg::status_t                    status;
  logic signed [sqsm_pkg::VALUE_W-1:0]  removed_value;
  logic [sqsm_pkg::COUNT_W-1:0]         entry_count;
  logic signed [sqsm_pkg::TOTAL_W-1:0]  total;
  logic signed [sqsm_pkg::VALUE_W-1:0]  mean;

  modport source (output valid, output status, output removed_value, output entry_count,
                  output total, output mean, input ready);
  modport sink   (input valid, input status, input removed_value, input entry_count,
                  input total, input mean, output ready);
endinterface

>>> rtl/core/sqsm_cell.sv
// One queue cell: holds a word, loads a new one or takes its neighbor's.
module sqsm_cell (
  input  logic                                clk,
  input  sqsm_pkg::cell_ctl_t                 ctl,
  input  logic signed [sqsm_pkg::VALUE_W-1:0] value,
  input  logic signed [sqsm_pkg::VALUE_W-1:0] nbr,
  output logic signed [sqsm_pkg::VALUE_W-1:0] data
);

  // Load on enqueue, advance on dequeue, otherwise hold
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      data <= value;
    end else if (ctl.shift) begin
      data <= nbr;
    end
  end

endmodule

>>> rtl/core/sqsm_div.sv
// Iterative signed-by-unsigned divider, several quotient bits per cycle.
module sqsm_div #(
  parameter int DW = sqsm_pkg::TOTAL_W,
  parameter int VW = sqsm_pkg::COUNT_W
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [DW-1:0]                dividend,
  input  logic [VW-1:0]                       divisor,
  output logic                                done,
  output logic signed [sqsm_pkg::VALUE_W-1:0] quotient
);

  localparam int RB    = sqsm_pkg::DIV_STEP_BITS;
  localparam int NSTEP = (DW + RB - 1) / RB;
  localparam int PW    = NSTEP * RB;
  localparam int CNTW  = (NSTEP > 1) ? $clog2(NSTEP) : 1;

  logic [VW-1:0]   rem;
  logic [VW-1:0]   dv;
  logic [PW-1:0]   dq;
  logic            neg;
  logic            busy;
  logic [CNTW-1:0] cnt;

  logic [DW-1:0]   mag;
  logic [VW:0]     trial;
  logic [VW-1:0]   rem_next;
  logic [PW-1:0]   dq_next;
  logic [sqsm_pkg::VALUE_W-1:0] qmag;

  // Magnitude of the dividend
  assign mag = dividend[DW-1] ? (~dividend + DW'(1)) : dividend;

  // Resolve RB quotient bits: shift in a dividend bit, compare, subtract
  always_comb begin
    rem_next = rem;
    dq_next  = dq;
    trial    = '0;
    for (int k = 0; k < RB; k++) begin
      trial   = {rem_next, dq_next[PW-1]};
      dq_next = {dq_next[PW-2:0], 1'b0};
      if (trial >= {1'b0, dv}) begin
        trial      = trial - {1'b0, dv};
        dq_next[0] = 1'b1;
      end
      rem_next = trial[VW-1:0];
    end
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNTW'(1);
      if (cnt == CNTW'(NSTEP - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      dq  <= PW'(mag);
      rem <= '0;
      dv  <= divisor;
      neg <= dividend[DW-1];
    end else if (busy) begin
      dq  <= dq_next;
      rem <= rem_next;
    end
  end

  // Apply the sign; truncation toward zero follows from dividing magnitudes
  assign qmag     = dq[sqsm_pkg::VALUE_W-1:0];
  assign quotient = neg ? -qmag : qmag;

endmodule

>>> rtl/core/shift_queue_with_sum_mean.sv
// Shift queue top level: front-aligned word queue with running sum and mean.
//
// A front-aligned queue of up to DEPTH signed 32-bit words. Each command
// (enqueue, dequeue, clear, query) on the item channel yields exactly one
// result: status, the word taken by a dequeue, the entry count, the sum of
// the stored words and their mean truncated toward zero (zero when empty).
// One command is in work at a time. When the queue is not empty after a
// command, the result waits for the mean of the running sum, which is
// SW = max(35, 33 + clog2(DEPTH)) bits wide, from an iterative divider
// that resolves four quotient bits per cycle; when it is empty, the
// divider is not started. Queue update, count and sum finish in the cycle
// of the transfer. A ready result waits in an output register, and the
// next command may be taken while it waits.
module shift_queue_with_sum_mean #(
  parameter int DEPTH = sqsm_pkg::DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  sqsm_item_if.sink            item,
  sqsm_result_if.source        result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = (33 + $clog2(DEPTH) > sqsm_pkg::TOTAL_W) ?
                      33 + $clog2(DEPTH) : sqsm_pkg::TOTAL_W;

  typedef enum logic {
    S_IDLE,
    S_DIV
  } state_t;

  state_t                              state;
  logic [CW-1:0]                       count;
  logic signed [SW-1:0]                sum;
  sqsm_pkg::status_t                   status_hold;
  logic signed [sqsm_pkg::VALUE_W-1:0] removed_hold;

  logic                                res_valid;
  sqsm_pkg::status_t                   res_status;
  logic signed [sqsm_pkg::VALUE_W-1:0] res_removed;
  logic [sqsm_pkg::COUNT_W-1:0]        res_count;
  logic signed [sqsm_pkg::TOTAL_W-1:0] res_total;
  logic signed [sqsm_pkg::VALUE_W-1:0] res_mean;

  logic                                accept;
  logic                                full;
  logic                                empty;
  logic                                do_load;
  logic                                do_shift;
  logic [CW-1:0]                       count_next;
  logic signed [SW-1:0]                sum_next;
  sqsm_pkg::status_t                   status_c;
  logic signed [sqsm_pkg::VALUE_W-1:0] removed_c;
  logic                                div_start;
  logic                                div_done;
  logic signed [sqsm_pkg::VALUE_W-1:0] div_quot;
  logic                                slot_free;
  logic                                finish;

  logic signed [sqsm_pkg::VALUE_W-1:0] cell_q [DEPTH];
  sqsm_pkg::cell_ctl_t                 cell_ctl [DEPTH];

  assign accept     = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);
  assign full       = (count == CW'(DEPTH));
  assign empty      = (count == '0);

  // Decode the command against the current fill level
  always_comb begin
    do_load    = 1'b0;
    do_shift   = 1'b0;
    count_next = count;
    sum_next   = sum;
    status_c   = sqsm_pkg::ST_DONE;
    removed_c  = '0;
    unique case (item.action)
      sqsm_pkg::ACT_ENQ: begin
        if (full) begin
          status_c = sqsm_pkg::ST_FULL;
        end else begin
          do_load    = 1'b1;
          count_next = count + CW'(1);
          sum_next   = sum + SW'(item.value);
        end
      end
      sqsm_pkg::ACT_DEQ: begin
        if (empty) begin
          status_c = sqsm_pkg::ST_EMPTY;
        end else begin
          do_shift   = 1'b1;
          removed_c  = cell_q[0];
          count_next = count - CW'(1);
          sum_next   = sum - SW'(cell_q[0]);
        end
      end
      sqsm_pkg::ACT_CLR: begin
        count_next = '0;
        sum_next   = '0;
      end
      sqsm_pkg::ACT_QRY: begin
      end
      default: begin
      end
    endcase
  end

  // Row of cells; each one but the last takes the word of the cell behind it on a dequeue
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [sqsm_pkg::VALUE_W-1:0] nbr;

    if (i == DEPTH - 1) begin : g_last
      assign nbr = cell_q[i];
    end else begin : g_mid
      assign nbr = cell_q[i + 1];
    end

    assign cell_ctl[i].load  = accept && do_load && (count == CW'(i));
    assign cell_ctl[i].shift = accept && do_shift;

    sqsm_cell u_cell (
      .clk   (clk),
      .ctl   (cell_ctl[i]),
      .value (item.value),
      .nbr   (nbr),
      .data  (cell_q[i])
    );
  end

  // Mean of the updated queue
  assign div_start = accept && (count_next != '0);

  sqsm_div #(
    .DW (SW),
    .VW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (count_next),
    .done     (div_done),
    .quotient (div_quot)
  );

  assign slot_free = !res_valid || result.ready;
  assign finish    = (state == S_DIV) && (empty || div_done) && slot_free;

  // Queue state, sequencing and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      sum       <= '0;
      res_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count        <= count_next;
            sum          <= sum_next;
            status_hold  <= status_c;
            removed_hold <= removed_c;
            state        <= S_DIV;
          end
        end
        S_DIV: begin
          if (finish) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase

      // Hand the result over once the output slot is free
      if (finish) begin
        res_valid   <= 1'b1;
        res_status  <= status_hold;
        res_removed <= removed_hold;
        res_count   <= sqsm_pkg::COUNT_W'(count);
        res_total   <= sqsm_pkg::TOTAL_W'(sum);
        res_mean    <= empty ? '0 : div_quot;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  assign result.valid         = res_valid;
  assign result.status        = res_status;
  assign result.removed_value = res_removed;
  assign result.entry_count   = res_count;
  assign result.total         = res_total;
  assign result.mean          = res_mean;

endmodule

>>> tb/tb_shift_queue_with_sum_mean.sv
// Testbench for the shift queue with sum and mean: directed and random command streams.
module tb_shift_queue_with_sum_mean;
  timeunit 1ns;
  timeprecision 1ps;

  import sqsm_pkg::*;

  localparam int QDEPTH     = DEPTH_DEF;
  localparam int CLK_PERIOD = 20;
  localparam int IDLE_LIMIT = 5000;
  localparam int TAIL_WAIT  = 20;
  localparam int PHASE_LEN  = 435;

  // One expected queue result
  typedef struct {
    status_t                     status;
    logic signed [VALUE_W-1:0]   removed_value;
    logic [COUNT_W-1:0]          entry_count;
    logic signed [TOTAL_W-1:0]   total;
    logic signed [VALUE_W-1:0]   mean;
  } queue_result_t;

  logic clk;
  logic rst;

  sqsm_item_if   cmd_ch ();
  sqsm_result_if res_ch ();

  shift_queue_with_sum_mean #(
    .DEPTH (QDEPTH)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .item   (cmd_ch),
    .result (res_ch)
  );

  // Shadow copy of the queue contents
  logic signed [VALUE_W-1:0] model_cells [QDEPTH];
  int                        model_fill;
  longint                    model_sum;

  queue_result_t expected_results [$];
  int error_count = 0;
  int src_idle_pct;
  int snk_stall_pct;
  int idle_cycles = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Apply one command to the shadow queue and return the result it yields
  function automatic queue_result_t apply_command(action_t act, logic signed [VALUE_W-1:0] word);
    queue_result_t r;
    longint        quotient;
    r.status        = ST_DONE;
    r.removed_value = '0;
    case (act)
      ACT_ENQ: begin
        if (model_fill >= QDEPTH) begin
          r.status = ST_FULL;
        end else begin
          model_cells[model_fill] = word;
          model_fill++;
          model_sum += word;
        end
      end
      ACT_DEQ: begin
        if (model_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.removed_value = model_cells[0];
          for (int i = 0; i + 1 < model_fill; i++)
            model_cells[i] = model_cells[i + 1];
          model_fill--;
          model_sum -= r.removed_value;
        end
      end
      ACT_CLR: begin
        model_fill = 0;
        model_sum  = 0;
      end
      default: ;
    endcase
    // Signed division truncates toward zero
    quotient      = (model_fill > 0) ? model_sum / longint'(model_fill) : 0;
    r.entry_count = model_fill[COUNT_W-1:0];
    r.total       = model_sum[TOTAL_W-1:0];
    r.mean        = quotient[VALUE_W-1:0];
    return r;
  endfunction

  // Send one command; called and returning at a falling edge
  task automatic send_command(action_t act, logic signed [VALUE_W-1:0] word);
    // Hold off with valid low for a random gap
    while ($urandom_range(99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      cmd_ch.value <= $urandom;
      @(negedge clk);
    end
    cmd_ch.valid  <= 1'b1;
    cmd_ch.action <= act;
    cmd_ch.value  <= word;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    expected_results.push_back(apply_command(act, word));
    @(negedge clk);
  endtask

  // Report one field mismatch
  task automatic compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, actual status %0d count %0d",
                 $time, res_ch.status, res_ch.entry_count);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("status", want.status, res_ch.status);
        compare_field("removed_value", want.removed_value, res_ch.removed_value);
        compare_field("entry_count", want.entry_count, res_ch.entry_count);
        compare_field("total", want.total, res_ch.total);
        compare_field("mean", want.mean, res_ch.mean);
      end
    end
  end

  // Stall the result side at random
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog: count cycles with work pending and no transfer on either side
  always @(posedge clk) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles = 0;
    end else if (cmd_ch.valid || expected_results.size() > 0) begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t ns: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Pick a word, weighted toward the extremes and small magnitudes
  function automatic logic signed [VALUE_W-1:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return VALUE_W'($signed($urandom_range(32)) - 16);
      default: return $urandom;
    endcase
  endfunction

  // Edges of the queue: empty, full, extreme words, clear and query
  task automatic test_directed();
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    send_command(ACT_QRY, 32'sd0);
    send_command(ACT_DEQ, 32'sd0);
    for (int i = 0; i < QDEPTH; i++)
      send_command(ACT_ENQ, 32'sh7FFF_FFFF);
    send_command(ACT_ENQ, 32'sd5);
    send_command(ACT_DEQ, 32'sd0);
    send_command(ACT_DEQ, 32'sd0);
    send_command(ACT_ENQ, 32'sh8000_0000);
    send_command(ACT_ENQ, 32'sh8000_0000);
    send_command(ACT_CLR, 32'sd0);
    send_command(ACT_QRY, 32'sd0);
    send_command(ACT_ENQ, -32'sd7);
    send_command(ACT_ENQ, -32'sd2);
    send_command(ACT_QRY, 32'sd0);
    send_command(ACT_DEQ, 32'sd0);
    send_command(ACT_DEQ, 32'sd0);
    send_command(ACT_DEQ, 32'sd0);
  endtask

  // Random command mix under the given idle and stall rates
  task automatic test_random(int count, int idle_pct, int stall_pct);
    int      roll;
    action_t act;
    src_idle_pct  = idle_pct;
    snk_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(99);
      if (roll < 44)      act = ACT_ENQ;
      else if (roll < 82) act = ACT_DEQ;
      else if (roll < 97) act = ACT_QRY;
      else                act = ACT_CLR;
      send_command(act, pick_word());
    end
  endtask

  // Drop valid, drain outstanding results, then let the pipeline settle
  task automatic finish_run();
    cmd_ch.valid <= 1'b0;
    while (expected_results.size() > 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
  endtask

  // Main sequence
  initial begin
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    model_fill    = 0;
    model_sum     = 0;
    foreach (model_cells[i]) model_cells[i] = '0;
    rst           = 1'b1;
    cmd_ch.valid  = 1'b0;
    cmd_ch.action = ACT_QRY;
    cmd_ch.value  = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(PHASE_LEN, 0, 0);
    test_random(PHASE_LEN, 55, 0);
    test_random(PHASE_LEN, 0, 55);
    test_random(PHASE_LEN, 19, 19);
    finish_run();

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
